// File: rtl/snch_pkg.sv
// Shared types, constants and helpers for the scene node clip and hit test block.
// Used by snch_table, snch_dp, snch_ctrl and the top level.
`default_nettype none

package snch_pkg;

    localparam int NODE_SLOTS = 256;
    localparam int SLOT_W     = $clog2(NODE_SLOTS);
    localparam int ID_W       = 8;
    localparam int COORD_W    = 16;
    localparam int STEP_W     = SLOT_W + 1;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;

    localparam logic [COORD_W-1:0] ROOT_CLIP = 16'd32000;

    localparam logic [1:0] ADDR_PARENT = 2'd0;
    localparam logic [1:0] ADDR_SCAN   = 2'd1;
    localparam logic [1:0] ADDR_CLIMB  = 2'd2;

    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_TOUCH  = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } origin_t;

    typedef struct packed {
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x0;
    } clip_t;

    typedef struct packed {
        logic            handler;
        logic [ID_W-1:0] parent;
    } link_t;

    typedef struct packed {
        origin_t origin;
        clip_t   clip;
        link_t   link;
    } entry_t;

    typedef struct packed {
        logic       load_in;
        logic [1:0] addr_sel;
        logic       bound_calc;
        logic       commit;
        logic       touch_start;
        logic       scan_dec;
        logic       climb_init;
        logic       climb_step;
        logic       hold_set;
        logic       fin_touch;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic in_op;
        logic held_zero;
        logic scan_empty;
        logic scan_last;
        logic hit;
        logic link_handler;
        logic link_parent_zero;
        logic steps_max;
        logic out_free;
    } status_t;

    function automatic logic signed [COORD_W:0] s17(input logic [COORD_W-1:0] v);
        return signed'({v[COORD_W-1], v});
    endfunction

    function automatic logic signed [COORD_W:0] u17(input logic [COORD_W-1:0] v);
        return signed'({1'b0, v});
    endfunction

endpackage

`default_nettype wire

// File: rtl/snch_table.sv
// Node table: origin, clip box and link per id, one read and one write port.
// Per-entry valid bits cleared at reset; invalid or out-of-range ids read as zero.
// Depends on snch_pkg.
`default_nettype none

module snch_table (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [snch_pkg::ID_W-1:0] raddr,
    output snch_pkg::entry_t           rdata,
    input  wire logic                  we,
    input  wire logic [snch_pkg::ID_W-1:0] waddr,
    input  wire snch_pkg::entry_t      wdata
);
    import snch_pkg::*;

    entry_t                mem [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] valid_reg;
    entry_t                rd_data_reg;
    logic                  rd_ok_reg;
    logic                  rd_in_range;
    logic [SLOT_W-1:0]     rd_idx;
    logic [SLOT_W-1:0]     wr_idx;

    assign rd_in_range = ({1'b0, raddr} < (ID_W+1)'(NODE_SLOTS));
    assign rd_idx      = raddr[SLOT_W-1:0];
    assign wr_idx      = waddr[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_idx] <= wdata;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_ok_reg <= rd_in_range && valid_reg[rd_idx];
        end
    end

    assign rdata = rd_ok_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: rtl/snch_dp.sv
// Datapath: input capture, bound arithmetic, scan and climb pointers, press state,
// result and output registers. Holds the node table. Depends on snch_pkg, snch_table.
`default_nettype none

module snch_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire snch_pkg::cmd_t               cmd,
    output snch_pkg::status_t                 status,
    input  wire logic [snch_pkg::IN_DATA_W-1:0] in_data,
    input  wire logic                         in_op,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [snch_pkg::OUT_DATA_W-1:0]   out_data
);
    import snch_pkg::*;

    logic [ID_W-1:0]    parent_reg;
    logic [COORD_W-1:0] offx_reg;
    logic [COORD_W-1:0] offy_reg;
    logic [COORD_W-1:0] w_reg;
    logic [COORD_W-1:0] h_reg;
    logic               hh_reg;
    logic               down_reg;
    logic [COORD_W-1:0] tx_reg;
    logic [COORD_W-1:0] ty_reg;

    logic [ID_W-1:0]    nf_reg;
    logic [COORD_W-1:0] last_x_reg;
    logic [COORD_W-1:0] last_y_reg;
    logic [ID_W-1:0]    held_reg;
    logic [ID_W-1:0]    scan_reg;
    logic [ID_W-1:0]    climb_reg;
    logic [STEP_W-1:0]  steps_reg;

    logic [COORD_W-1:0] xtl_reg;
    logic [COORD_W-1:0] ytl_reg;
    logic [COORD_W-1:0] xbr_reg;
    logic [COORD_W-1:0] ybr_reg;
    clip_t              pclip_reg;

    logic [ID_W-1:0]    res_id_reg;
    logic               res_hc_reg;
    logic               res_ps_reg;
    logic [COORD_W-1:0] res_dx_reg;
    logic [COORD_W-1:0] res_dy_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [ID_W-1:0]    raddr;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               wr_en;

    origin_t            porig;
    clip_t              pclip;
    logic [COORD_W-1:0] xtl_c;
    logic [COORD_W-1:0] ytl_c;
    logic               full;
    logic               reject;
    logic [COORD_W-1:0] xtl_p;
    logic [COORD_W-1:0] ytl_p;
    logic [COORD_W-1:0] xbr_p;
    logic [COORD_W-1:0] ybr_p;
    logic               last_nz;

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_SCAN:  raddr = scan_reg;
            ADDR_CLIMB: raddr = climb_reg;
            default:    raddr = parent_reg;
        endcase
    end

    snch_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (raddr),
        .rdata (rd_entry),
        .we    (wr_en),
        .waddr (nf_reg),
        .wdata (wr_entry)
    );

    // parent bounds; root when parent is zero
    always_comb
    begin
        if (parent_reg == '0)
        begin
            porig = '0;
            pclip = '{y1: ROOT_CLIP, x1: ROOT_CLIP, y0: '0, x0: '0};
        end
        else
        begin
            porig = rd_entry.origin;
            pclip = rd_entry.clip;
        end
        xtl_c = porig.x + offx_reg;
        ytl_c = porig.y + offy_reg;
    end

    always_comb
    begin
        full   = (nf_reg == '0) || ({1'b0, nf_reg} >= (ID_W+1)'(NODE_SLOTS));
        reject = (s17(xtl_reg) > u17(pclip_reg.x1)) || (s17(ytl_reg) > u17(pclip_reg.y1))
              || (s17(xbr_reg) < u17(pclip_reg.x0)) || (s17(ybr_reg) < u17(pclip_reg.y0));
        xtl_p  = xtl_reg[COORD_W-1] ? '0 : xtl_reg;
        ytl_p  = ytl_reg[COORD_W-1] ? '0 : ytl_reg;
        xbr_p  = xbr_reg[COORD_W-1] ? '0 : xbr_reg;
        ybr_p  = ybr_reg[COORD_W-1] ? '0 : ybr_reg;
        wr_entry.origin.x    = xtl_reg;
        wr_entry.origin.y    = ytl_reg;
        wr_entry.clip.x0     = (xtl_p > pclip_reg.x0) ? xtl_p : pclip_reg.x0;
        wr_entry.clip.y0     = (ytl_p > pclip_reg.y0) ? ytl_p : pclip_reg.y0;
        wr_entry.clip.x1     = (xbr_p < pclip_reg.x1) ? xbr_p : pclip_reg.x1;
        wr_entry.clip.y1     = (ybr_p < pclip_reg.y1) ? ybr_p : pclip_reg.y1;
        wr_entry.link.handler = hh_reg;
        wr_entry.link.parent  = parent_reg;
        wr_en = cmd.commit && !full && !reject;
    end

    assign last_nz = (last_x_reg != '0) || (last_y_reg != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            parent_reg <= in_data[7:0];
            offx_reg   <= in_data[23:8];
            offy_reg   <= in_data[39:24];
            w_reg      <= in_data[55:40];
            h_reg      <= in_data[71:56];
            hh_reg     <= in_data[72];
            down_reg   <= in_data[73];
            tx_reg     <= in_data[89:74];
            ty_reg     <= in_data[105:90];
        end
        if (cmd.bound_calc)
        begin
            xtl_reg   <= xtl_c;
            ytl_reg   <= ytl_c;
            xbr_reg   <= xtl_c + w_reg;
            ybr_reg   <= ytl_c + h_reg;
            pclip_reg <= pclip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg        <= ID_W'(1);
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            held_reg      <= '0;
            scan_reg      <= '0;
            climb_reg     <= '0;
            steps_reg     <= '0;
            res_id_reg    <= '0;
            res_hc_reg    <= 1'b0;
            res_ps_reg    <= 1'b0;
            res_dx_reg    <= '0;
            res_dy_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cmd.load_in && (in_op == OP_CREATE) && (in_data[7:0] == '0))
            begin
                nf_reg <= ID_W'(1);
            end
            if (cmd.commit)
            begin
                res_id_reg <= wr_en ? nf_reg : '0;
                res_hc_reg <= 1'b0;
                res_ps_reg <= 1'b0;
                res_dx_reg <= '0;
                res_dy_reg <= '0;
                if (wr_en)
                begin
                    nf_reg <= nf_reg + ID_W'(1);
                end
            end
            if (cmd.touch_start)
            begin
                scan_reg <= nf_reg - ID_W'(1);
                if (down_reg)
                begin
                    res_dx_reg <= last_nz ? (tx_reg - last_x_reg) : '0;
                    res_dy_reg <= last_nz ? (ty_reg - last_y_reg) : '0;
                    last_x_reg <= tx_reg;
                    last_y_reg <= ty_reg;
                end
                else
                begin
                    res_dx_reg <= '0;
                    res_dy_reg <= '0;
                    last_x_reg <= '0;
                    last_y_reg <= '0;
                end
            end
            if (cmd.scan_dec)
            begin
                scan_reg <= scan_reg - ID_W'(1);
            end
            if (cmd.climb_init)
            begin
                climb_reg <= scan_reg;
                steps_reg <= '0;
            end
            if (cmd.climb_step)
            begin
                climb_reg <= rd_entry.link.parent;
                steps_reg <= steps_reg + STEP_W'(1);
            end
            if (cmd.hold_set)
            begin
                held_reg <= climb_reg;
            end
            if (cmd.fin_touch)
            begin
                res_id_reg <= held_reg;
                res_hc_reg <= (held_reg != '0);
                res_ps_reg <= (held_reg != '0) && down_reg;
                if (!down_reg)
                begin
                    held_reg <= '0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {6'd0, res_dy_reg, res_dx_reg, res_ps_reg, res_hc_reg,
                                  res_id_reg};
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.in_op            = in_op;
        status.held_zero        = (held_reg == '0);
        status.scan_empty       = (nf_reg == ID_W'(1));
        status.scan_last        = (scan_reg == ID_W'(1));
        status.hit              = (s17(tx_reg) >= u17(rd_entry.clip.x0))
                               && (s17(tx_reg) <= u17(rd_entry.clip.x1))
                               && (s17(ty_reg) >= u17(rd_entry.clip.y0))
                               && (s17(ty_reg) <= u17(rd_entry.clip.y1));
        status.link_handler     = rd_entry.link.handler;
        status.link_parent_zero = (rd_entry.link.parent == '0);
        status.steps_max        = (steps_reg == STEP_W'(NODE_SLOTS));
        status.out_free         = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/snch_ctrl.sv
// Controller: sequences create, hit scan and parent climb over the datapath.
// Depends on snch_pkg.
`default_nettype none

module snch_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire snch_pkg::status_t status,
    output snch_pkg::cmd_t    cmd
);
    import snch_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_C_RD    = 4'd1;
    localparam logic [3:0] ST_C_BOUND = 4'd2;
    localparam logic [3:0] ST_C_WR    = 4'd3;
    localparam logic [3:0] ST_T_START = 4'd4;
    localparam logic [3:0] ST_S_RD    = 4'd5;
    localparam logic [3:0] ST_S_CHK   = 4'd6;
    localparam logic [3:0] ST_L_RD    = 4'd7;
    localparam logic [3:0] ST_L_CHK   = 4'd8;
    localparam logic [3:0] ST_T_FIN   = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.addr_sel = ADDR_PARENT;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (status.in_op == OP_CREATE) ? ST_C_RD : ST_T_START;
                end
            end
            ST_C_RD:
            begin
                state_next = ST_C_BOUND;
            end
            ST_C_BOUND:
            begin
                cmd.bound_calc = 1'b1;
                state_next     = ST_C_WR;
            end
            ST_C_WR:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_T_START:
            begin
                cmd.touch_start = 1'b1;
                state_next = (!status.held_zero || status.scan_empty) ? ST_T_FIN : ST_S_RD;
            end
            ST_S_RD:
            begin
                cmd.addr_sel = ADDR_SCAN;
                state_next   = ST_S_CHK;
            end
            ST_S_CHK:
            begin
                if (status.hit)
                begin
                    cmd.climb_init = 1'b1;
                    state_next     = ST_L_RD;
                end
                else
                begin
                    cmd.scan_dec = 1'b1;
                    state_next   = status.scan_last ? ST_T_FIN : ST_S_RD;
                end
            end
            ST_L_RD:
            begin
                cmd.addr_sel = ADDR_CLIMB;
                state_next   = ST_L_CHK;
            end
            ST_L_CHK:
            begin
                if (status.link_handler)
                begin
                    cmd.hold_set = 1'b1;
                    state_next   = ST_T_FIN;
                end
                else if (status.steps_max || status.link_parent_zero)
                begin
                    cmd.scan_dec = 1'b1;
                    state_next   = status.scan_last ? ST_T_FIN : ST_S_RD;
                end
                else
                begin
                    cmd.climb_step = 1'b1;
                    state_next     = ST_L_RD;
                end
            end
            ST_T_FIN:
            begin
                cmd.fin_touch = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/scene_node_clip_and_hit_test.sv
// Scene node table with clip boxes and touch hit testing; top level.
// Create: reads the parent, computes the bounds, commits, then loads the result.
// Touch: scans ids downward and climbs the parents of a hit (up to 255 ids, 257 checks per
// climb); a new beat is accepted only after the result is loaded.
// Reset clears control state and the per-entry valid bits; no clearing pass.
// Depends on snch_pkg, snch_ctrl, snch_dp, snch_table.
`default_nettype none

module scene_node_clip_and_hit_test (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // parent_node[7:0], offset_x[23:8], offset_y[39:24], node_width[55:40],
    // node_height[71:56], has_handler[72], touch_down[73], touch_x[89:74],
    // touch_y[105:90], zero fill[111:106]
    input  wire logic [snch_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op[0]
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // node_id[7:0], handler_called[8], press_state[9], delta_x[25:10],
    // delta_y[41:26], zero fill[47:42]
    output logic [snch_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import snch_pkg::*;

    cmd_t    cmd;
    status_t status;

    snch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    snch_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
